/* design/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned FieldW          = 20;
  localparam int unsigned DefHeapBytes    = 1048576;
  localparam int unsigned DefHeaderBytes  = 24;
  localparam int unsigned DefAlignBytes   = 8;
  localparam int unsigned MinSplitPayload = 8;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StZero = 2'd1;
  localparam logic [1:0] StOom  = 2'd2;
  localparam logic [1:0] StNull = 2'd3;

  typedef struct packed {
    logic              command;
    logic [FieldW-1:0] request_size;
    logic [FieldW-1:0] payload_offset_in;
    logic              pointer_is_null;
  } ffha_cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FieldW-1:0] payload_offset_out;
  } ffha_res_t;

endpackage

/* design/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing; block headers live in one memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single
// result appears for one cycle with done_o and cannot be held off. Headers
// sit in a synchronous memory indexed by header offset, and each allocate
// or non-null free walks the chain of headers from offset 0 with a read
// state and an evaluate state per block. An allocate walks up to the fit;
// a free walks up to the named block, plus one read for its right neighbour.
// Zero-size requests and null frees answer straight from the idle state.
// After reset the block is busy for one cycle while the initial free header
// is written.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::DefHeapBytes,
  parameter int unsigned HEADER_BYTES = ffha_pkg::DefHeaderBytes,
  parameter int unsigned ALIGN_BYTES  = ffha_pkg::DefAlignBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::ffha_cmd_t cmd_i,
  output logic                done_o,
  output ffha_pkg::ffha_res_t res_o
);
  import ffha_pkg::*;

  localparam int unsigned OffW   = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned SzW    = $clog2(HEAP_BYTES);
  localparam int unsigned GranSh =
    ((HEADER_BYTES % 8 == 0) && (ALIGN_BYTES % 8 == 0)) ? 3 :
    ((HEADER_BYTES % 4 == 0) && (ALIGN_BYTES % 4 == 0)) ? 2 : 0;
  localparam int unsigned Depth  = HEAP_BYTES >> GranSh;
  localparam int unsigned AddrW  = $clog2(Depth);

  localparam logic [OffW-1:0] Heap = OffW'(HEAP_BYTES);
  localparam logic [OffW-1:0] Hdr  = OffW'(HEADER_BYTES);
  localparam logic [OffW-1:0] AlM  = OffW'(ALIGN_BYTES - 1);
  localparam logic [OffW-1:0] MinS = OffW'(MinSplitPayload);

  localparam logic [2:0] SInit = 3'd0;
  localparam logic [2:0] SIdle = 3'd1;
  localparam logic [2:0] SRd   = 3'd2;
  localparam logic [2:0] SEv   = 3'd3;
  localparam logic [2:0] SRdN  = 3'd4;
  localparam logic [2:0] SEvN  = 3'd5;
  localparam logic [2:0] SWr2  = 3'd6;

  typedef struct packed {
    logic           free;
    logic [SzW-1:0] size;
  } hdr_t;

  hdr_t mem [Depth];
  hdr_t rdata_q;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  hdr_t wdata;

  logic [2:0]      state_q, state_d;
  logic            cmd_q, cmd_d;
  logic [OffW-1:0] req_q, req_d, ptr_q, ptr_d;
  logic [OffW-1:0] cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d;
  logic            prev_free_q, prev_free_d;
  logic [SzW-1:0]  prev_size_q, prev_size_d, cur_size_q, cur_size_d;
  logic [OffW-1:0] w2_off_q, w2_off_d;
  logic [SzW-1:0]  w2_size_q, w2_size_d;
  logic            done_q, done_d;
  ffha_res_t       res_q, res_d;

  logic [OffW-1:0] rsz, rd_size, blk_end, merge_sz;
  logic [OffW-1:0] rounded;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign rd_size = OffW'(rdata_q.size);
  assign blk_end = cur_q + Hdr + rd_size;
  assign rounded = (OffW'(cmd_i.request_size) + AlM) & ~AlM;
  assign raddr   = (state_q == SRdN) ? nxt_q[GranSh +: AddrW] : cur_q[GranSh +: AddrW];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    ptr_d       = ptr_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    prev_free_d = prev_free_q;
    prev_size_d = prev_size_q;
    cur_size_d  = cur_size_q;
    w2_off_d    = w2_off_q;
    w2_size_d   = w2_size_q;
    done_d      = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = cur_q[GranSh +: AddrW];
    wdata       = '0;
    rsz         = '0;
    merge_sz    = '0;

    unique case (state_q)
      SInit: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = '{free: 1'b1, size: SzW'(Heap - Hdr)};
        state_d = SIdle;
      end
      SIdle: begin
        if (start) begin
          cmd_d       = cmd_i.command;
          req_d       = rounded;
          ptr_d       = OffW'(cmd_i.payload_offset_in);
          cur_d       = '0;
          prev_free_d = 1'b0;
          if (cmd_i.command == CmdAlloc && cmd_i.request_size == '0) begin
            done_d = 1'b1;
            res_d  = '{status: StZero, payload_offset_out: '0};
          end else if (cmd_i.command == CmdFree && cmd_i.pointer_is_null) begin
            done_d = 1'b1;
            res_d  = '{status: StNull, payload_offset_out: '0};
          end else begin
            state_d = SRd;
          end
        end
      end
      SRd: begin
        // End of chain, or walked past the freed pointer
        if (cur_q >= Heap || (cmd_q == CmdFree && cur_q + Hdr > ptr_q)) begin
          done_d  = 1'b1;
          res_d   = '{status: (cmd_q == CmdAlloc) ? StOom : StOk, payload_offset_out: '0};
          state_d = SIdle;
        end else begin
          state_d = SEv;
        end
      end
      SEv: begin
        if (cmd_q == CmdAlloc) begin
          if (rdata_q.free && rd_size >= req_q) begin
            we = 1'b1;
            if (rd_size >= req_q + Hdr + MinS) begin
              rsz       = rd_size - req_q - Hdr;
              wdata     = '{free: 1'b0, size: SzW'(req_q)};
              w2_off_d  = cur_q + Hdr + req_q;
              w2_size_d = SzW'(rsz);
              state_d   = SWr2;
            end else begin
              wdata   = '{free: 1'b0, size: rdata_q.size};
              done_d  = 1'b1;
              res_d   = '{status: StOk, payload_offset_out: FieldW'(cur_q + Hdr)};
              state_d = SIdle;
            end
          end else begin
            cur_d   = blk_end;
            state_d = SRd;
          end
        end else if (cur_q + Hdr == ptr_q) begin
          if (rdata_q.free) begin
            done_d  = 1'b1;
            res_d   = '{status: StOk, payload_offset_out: '0};
            state_d = SIdle;
          end else if (blk_end < Heap) begin
            cur_size_d = rdata_q.size;
            nxt_d      = blk_end;
            state_d    = SRdN;
          end else begin
            // No right neighbour: merge leftwards only
            merge_sz = rd_size + (prev_free_q ? OffW'(prev_size_q) + Hdr : '0);
            we       = 1'b1;
            waddr    = prev_free_q ? prev_q[GranSh +: AddrW] : cur_q[GranSh +: AddrW];
            wdata    = '{free: 1'b1, size: SzW'(merge_sz)};
            done_d   = 1'b1;
            res_d    = '{status: StOk, payload_offset_out: '0};
            state_d  = SIdle;
          end
        end else begin
          prev_d      = cur_q;
          prev_free_d = rdata_q.free;
          prev_size_d = rdata_q.size;
          cur_d       = blk_end;
          state_d     = SRd;
        end
      end
      SRdN: begin
        state_d = SEvN;
      end
      SEvN: begin
        merge_sz = OffW'(cur_size_q)
                 + (prev_free_q ? OffW'(prev_size_q) + Hdr : '0)
                 + (rdata_q.free ? rd_size + Hdr : '0);
        we      = 1'b1;
        waddr   = prev_free_q ? prev_q[GranSh +: AddrW] : cur_q[GranSh +: AddrW];
        wdata   = '{free: 1'b1, size: SzW'(merge_sz)};
        done_d  = 1'b1;
        res_d   = '{status: StOk, payload_offset_out: '0};
        state_d = SIdle;
      end
      SWr2: begin
        we      = 1'b1;
        waddr   = w2_off_q[GranSh +: AddrW];
        wdata   = '{free: 1'b1, size: w2_size_q};
        done_d  = 1'b1;
        res_d   = '{status: StOk, payload_offset_out: FieldW'(cur_q + Hdr)};
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    req_q       <= req_d;
    ptr_q       <= ptr_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    nxt_q       <= nxt_d;
    prev_free_q <= prev_free_d;
    prev_size_q <= prev_size_d;
    cur_size_q  <= cur_size_d;
    w2_off_q    <= w2_off_d;
    w2_size_q   <= w2_size_d;
    res_q       <= res_d;
  end

  assign busy   = (state_q != SIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the first-fit heap allocator. It keeps its own block list,
// predicts the status and payload offset of every command and checks each
// done_o strobe against the oldest prediction. Directed corner cases come
// first, then random allocate/free traffic with random start gaps.
// ----------------------------------------------------------------------------
module tb;
  import ffha_pkg::*;

  localparam int unsigned HeapBytes = DefHeapBytes;
  localparam int unsigned HdrBytes  = DefHeaderBytes;
  localparam int unsigned AlignB    = DefAlignBytes;
  localparam int unsigned MaxLive   = 40;
  localparam int unsigned RandItems = 600;
  localparam int unsigned CycleCap  = 2000000;
  localparam int unsigned CmdW      = $bits(ffha_cmd_t);

  class heap_scoreboard;
    int unsigned blk_size[$];
    bit          blk_free[$];
    ffha_res_t   expected_q[$];
    int          mismatches;
    int          checked;

    function new();
      blk_size = '{HeapBytes - HdrBytes};
      blk_free = '{1'b1};
    endfunction

    function void coalesce();
      int i;
      i = 0;
      while (i + 1 < blk_size.size()) begin
        if (blk_free[i] && blk_free[i+1]) begin
          blk_size[i] += HdrBytes + blk_size[i+1];
          blk_size.delete(i + 1);
          blk_free.delete(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    // Predict the result of an accepted command and queue it.
    function ffha_res_t note_command(ffha_cmd_t c);
      ffha_res_t   r;
      int unsigned req;
      int unsigned off;
      r = '0;
      off = 0;
      if (c.command == CmdAlloc) begin
        req = 32'(c.request_size);
        if (req == 0) begin
          r.status = StZero;
        end else begin
          if (req % AlignB != 0) req += AlignB - req % AlignB;
          r.status = StOom;
          for (int i = 0; i < blk_size.size(); i++) begin
            if (blk_free[i] && blk_size[i] >= req) begin
              if (blk_size[i] >= req + HdrBytes + MinSplitPayload) begin
                blk_size.insert(i + 1, blk_size[i] - req - HdrBytes);
                blk_free.insert(i + 1, 1'b1);
                blk_size[i] = req;
              end
              blk_free[i] = 1'b0;
              r.status = StOk;
              r.payload_offset_out = FieldW'(off + HdrBytes);
              break;
            end
            off += HdrBytes + blk_size[i];
          end
        end
      end else if (c.pointer_is_null) begin
        r.status = StNull;
      end else begin
        r.status = StOk;
        for (int i = 0; i < blk_size.size(); i++) begin
          if (off + HdrBytes == 32'(c.payload_offset_in)) begin
            blk_free[i] = 1'b1;
            coalesce();
            break;
          end
          off += HdrBytes + blk_size[i];
        end
      end
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(ffha_res_t got);
      ffha_res_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d offset=%0d",
                   got.status, got.payload_offset_out);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.status !== exp.status || got.payload_offset_out !== exp.payload_offset_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: transaction %0d: expected status=%0d offset=%0d, got status=%0d offset=%0d",
                   checked, exp.status, exp.payload_offset_out, got.status,
                   got.payload_offset_out);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ffha_cmd_t cmd_i;
  logic      done_o;
  ffha_res_t res_o;

  heap_scoreboard sb = new();
  int unsigned    cycles = 0;
  bit             gaps_on;
  int unsigned    live_q[$];
  int unsigned    freed_q[$];

  first_fit_heap_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) sb.check_result(res_o);
    if (cycles > CycleCap) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("** first_fit_heap_allocator: FAILED **");
      $finish;
    end
  end

  // Drive one command and hold it until busy is low at a rising edge.
  task automatic issue(input ffha_cmd_t c);
    ffha_res_t exp;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
    exp = sb.note_command(c);
    if (c.command == CmdAlloc && exp.status == StOk)
      live_q.push_back(32'(exp.payload_offset_out));
  endtask

  task automatic do_alloc(input int unsigned sz);
    ffha_cmd_t c;
    c = CmdW'({$urandom, $urandom});
    c.command = CmdAlloc;
    c.request_size = FieldW'(sz);
    issue(c);
  endtask

  task automatic do_free(input int unsigned ptr, input bit is_null);
    ffha_cmd_t c;
    c = CmdW'({$urandom, $urandom});
    c.command = CmdFree;
    c.payload_offset_in = FieldW'(ptr);
    c.pointer_is_null = is_null;
    issue(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned k;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    gaps_on = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corner cases: zero size, whole heap, out of memory, splits, merges.
    do_alloc(0);
    do_alloc(HeapBytes - HdrBytes);
    do_alloc(1);
    do_free(HdrBytes, 1'b0);
    do_alloc(20'hFFFFF);
    do_alloc(1);
    do_alloc(8);
    do_alloc(13);
    do_free(56, 1'b0);
    do_free(56, 1'b0);
    do_free(57, 1'b0);
    do_free(HdrBytes, 1'b1);
    do_free(HdrBytes, 1'b0);
    do_free(88, 1'b0);
    do_alloc(HeapBytes - HdrBytes - 23);
    do_free(HdrBytes, 1'b0);
    do_alloc(HeapBytes - 2 * HdrBytes - 8);
    do_alloc(8);
    do_alloc(1);
    do_free(HdrBytes, 1'b0);
    do_free(HeapBytes - 8, 1'b0);
    do_free(20'hFFFFF, 1'b0);
    live_q.delete();
    drain();

    gaps_on = 1'b1;
    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) drain();
      if (n == RandItems - 100) gaps_on = 1'b0;
      if (live_q.size() < MaxLive && $urandom_range(0, 99) < 55) begin
        k = $urandom_range(0, 99);
        if (k < 70) do_alloc($urandom_range(1, 256));
        else if (k < 85) do_alloc($urandom_range(1, 4096));
        else if (k < 90) do_alloc(0);
        else do_alloc($urandom_range(0, 20'hFFFFF));
      end else begin
        k = $urandom_range(0, 99);
        if (k < 70 && live_q.size() != 0) begin
          k = $urandom_range(0, live_q.size() - 1);
          freed_q.push_back(live_q[k]);
          do_free(live_q[k], 1'b0);
          live_q.delete(k);
        end else if (k < 80) begin
          do_free($urandom_range(0, 20'hFFFFF), 1'b1);
        end else if (k < 90 || freed_q.size() == 0) begin
          do_free($urandom_range(0, 20'hFFFFF), 1'b0);
        end else begin
          do_free(freed_q[$urandom_range(0, freed_q.size() - 1)], 1'b0);
        end
      end
    end
    drain();

    $display("Ran %0d commands: directed corners then random allocate/free mix,",
             sb.checked);
    $display("with null, stale and invalid frees; %0d mismatches.", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("** first_fit_heap_allocator: PASSED **");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("ERROR: %0d results never arrived", sb.expected_q.size());
      $display("** first_fit_heap_allocator: FAILED **");
    end
    $finish;
  end

endmodule
